FILE: rtl/assert_macros.svh
// Assertion macros shared by the RTL. Each use sits on a line of its own.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// When the antecedent holds, the consequent must hold in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/tstt_pkg.sv
`timescale 1ns / 1ps

package tstt_pkg;

    localparam int MV_W       = 12;
    localparam int TEMP_W     = 7;
    localparam int CAP_DEPTH  = 8;
    localparam int CAP_SHIFT  = $clog2(CAP_DEPTH);
    localparam int CAP_IDX_W  = (CAP_DEPTH > 1) ? $clog2(CAP_DEPTH) : 1;
    localparam int CAP_FILL_W = $clog2(CAP_DEPTH + 2);
    localparam int CAP_SUM_W  = MV_W + CAP_SHIFT;
    localparam int AVG_SUM_W  = MV_W + 2;

    localparam logic [MV_W-1:0] CLAMP_HIGH = 12'd2600;
    localparam logic [MV_W-1:0] CLAMP_LOW  = 12'd200;

    localparam int TABLE_LEN = 67;
    localparam logic signed [TEMP_W-1:0] TEMP_FIRST = -7'sd10;
    localparam logic signed [TEMP_W-1:0] TEMP_BELOW = 7'sd60;

    // Descending millivolt thresholds, one per degree from -10 C upwards.
    localparam logic [MV_W-1:0] THRESHOLDS [TABLE_LEN] = '{
        12'd1482, 12'd1467, 12'd1452, 12'd1437, 12'd1422, 12'd1407, 12'd1392,
        12'd1377, 12'd1362, 12'd1347, 12'd1332, 12'd1318, 12'd1303, 12'd1288,
        12'd1273, 12'd1258, 12'd1240, 12'd1210, 12'd1180, 12'd1150, 12'd1130,
        12'd1110, 12'd1090, 12'd1070, 12'd1050, 12'd1030, 12'd1010, 12'd994,
        12'd977,  12'd962,  12'd946,  12'd931,  12'd915,  12'd900,  12'd884,
        12'd869,  12'd853,  12'd838,  12'd822,  12'd807,  12'd791,  12'd776,
        12'd760,  12'd745,  12'd729,  12'd714,  12'd698,  12'd683,  12'd667,
        12'd652,  12'd637,  12'd621,  12'd606,  12'd590,  12'd580,  12'd565,
        12'd550,  12'd535,  12'd520,  12'd505,  12'd490,  12'd475,  12'd460,
        12'd445,  12'd430,  12'd415,  12'd400
    };

    // First threshold the value reaches wins; scanning from the end keeps priority.
    function automatic logic signed [TEMP_W-1:0] lookup_temp(input logic [MV_W-1:0] v);
        logic signed [TEMP_W-1:0] t;
        t = TEMP_BELOW;
        for (int i = TABLE_LEN - 1; i >= 0; i--) begin
            if (v >= THRESHOLDS[i]) begin
                t = TEMP_FIRST + TEMP_W'(i);
            end
        end
        return t;
    endfunction

endpackage

FILE: rtl/tstt_avg4.sv
`timescale 1ns / 1ps

// Four-entry moving average with a running sum. A priming write fills every
// entry with the incoming value. o_avg is the average including i_value.
module tstt_avg4 (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  logic                     i_prime,
    input  logic [tstt_pkg::MV_W-1:0] i_value,
    output logic [tstt_pkg::MV_W-1:0] o_avg
);

    logic [tstt_pkg::MV_W-1:0]    r_ring [4];
    logic [1:0]                   r_ptr;
    logic [tstt_pkg::AVG_SUM_W-1:0] r_sum;
    logic [tstt_pkg::AVG_SUM_W-1:0] n_sum;

    always_comb begin
        if (i_prime) begin
            n_sum = {i_value, 2'b00};
        end else begin
            n_sum = r_sum - tstt_pkg::AVG_SUM_W'(r_ring[r_ptr])
                    + tstt_pkg::AVG_SUM_W'(i_value);
        end
    end

    assign o_avg = n_sum[tstt_pkg::AVG_SUM_W-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr <= 2'd0;
        end else if (i_en) begin
            r_ptr <= i_prime ? 2'd1 : r_ptr + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sum <= n_sum;
            if (i_prime) begin
                for (int i = 0; i < 4; i++) begin
                    r_ring[i] <= i_value;
                end
            end else begin
                r_ring[r_ptr] <= i_value;
            end
        end
    end

endmodule

FILE: rtl/thermistor_sample_to_temperature.sv
`timescale 1ns / 1ps

// Thermistor sample to temperature. One millivolt sample is taken per clock
// transaction; samples flagged bad in tuser are dropped. The capture stage
// keeps a running sum over the last eight good samples and, once more than
// eight have arrived, passes on their floored mean (before that, the first
// nonzero sample). While enabled, two four-entry moving averages (the first
// clamped to 200..2600 mV) feed a table lookup giving -10..56 C, or 60 C
// below the table. One new sample is accepted every cycle while the output
// is not stalled; a result passes through the capture, first average,
// second average and lookup registers. With the enable register low no
// results are produced, though the capture stage still tracks the samples.
module thermistor_sample_to_temperature (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wen,
    input  logic        i_cfg_wdata,   // enable
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [15:0] i_s_tdata,     // [11:0] sample_mv, zero padding above
    input  logic        i_s_tuser,     // sample_bad
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata      // [6:0] temperature_c, [18:7] filtered_mv
);

    `include "assert_macros.svh"

    localparam int MV_W = tstt_pkg::MV_W;

    logic r_enable;

    // Capture stage state.
    logic [MV_W-1:0]                  r_cap_ring [tstt_pkg::CAP_DEPTH];
    logic [tstt_pkg::CAP_IDX_W-1:0]   r_cap_wr;
    logic [tstt_pkg::CAP_FILL_W-1:0]  r_cap_fill;
    logic [tstt_pkg::CAP_SUM_W-1:0]   r_cap_sum;
    logic [MV_W-1:0]                  r_cur_mv;
    logic [tstt_pkg::CAP_FILL_W-1:0]  n_cap_fill;
    logic [tstt_pkg::CAP_SUM_W-1:0]   n_cap_sum;
    logic [MV_W-1:0]                  n_cur_mv;
    logic [MV_W-1:0]                  w_sample;
    logic [MV_W-1:0]                  w_evict;

    // Pipeline registers.
    logic                      r_s1_valid;
    logic [MV_W-1:0]           r_s1_mv;
    logic                      r_s2_valid;
    logic                      r_s2_prime;
    logic [MV_W-1:0]           r_s2_mv;
    logic                      r_s3_valid;
    logic [MV_W-1:0]           r_s3_mv;
    logic                      r_o_valid;
    logic signed [tstt_pkg::TEMP_W-1:0] r_o_temp;
    logic [MV_W-1:0]           r_o_mv;
    logic                      r_primed;

    logic w_rdy_out, w_rdy3, w_rdy2, w_rdy1;
    logic w_accept, w_good, w_adv2, w_adv3;
    logic [MV_W-1:0] w_avg2, w_clamp2, w_avg3;

    assign w_rdy_out = !r_o_valid || i_m_tready;
    assign w_rdy3    = !r_s3_valid || w_rdy_out;
    assign w_rdy2    = !r_s2_valid || w_rdy3;
    assign w_rdy1    = !r_s1_valid || w_rdy2;

    assign o_s_tready = w_rdy1;
    assign w_accept   = i_s_tvalid && w_rdy1;
    assign w_good     = w_accept && !i_s_tuser;
    assign w_sample   = i_s_tdata[MV_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= 1'b0;
        end else if (i_cfg_wen) begin
            r_enable <= i_cfg_wdata;
        end
    end

    // Entries not yet written leave the sum untouched until the ring is full.
    assign w_evict = (r_cap_fill >= tstt_pkg::CAP_FILL_W'(tstt_pkg::CAP_DEPTH))
                     ? r_cap_ring[r_cap_wr] : '0;

    always_comb begin
        n_cap_sum  = r_cap_sum - tstt_pkg::CAP_SUM_W'(w_evict)
                     + tstt_pkg::CAP_SUM_W'(w_sample);
        n_cap_fill = r_cap_fill;
        if (r_cap_fill < tstt_pkg::CAP_FILL_W'(tstt_pkg::CAP_DEPTH + 1)) begin
            n_cap_fill = r_cap_fill + tstt_pkg::CAP_FILL_W'(1);
        end
        n_cur_mv = r_cur_mv;
        if (n_cap_fill > tstt_pkg::CAP_FILL_W'(tstt_pkg::CAP_DEPTH)) begin
            n_cur_mv = n_cap_sum[tstt_pkg::CAP_SUM_W-1:tstt_pkg::CAP_SHIFT];
        end else if (r_cur_mv == '0) begin
            n_cur_mv = w_sample;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap_wr   <= '0;
            r_cap_fill <= '0;
            r_cap_sum  <= '0;
            r_cur_mv   <= '0;
        end else if (w_good) begin
            r_cap_wr   <= (r_cap_wr == tstt_pkg::CAP_IDX_W'(tstt_pkg::CAP_DEPTH - 1))
                          ? '0 : r_cap_wr + tstt_pkg::CAP_IDX_W'(1);
            r_cap_fill <= n_cap_fill;
            r_cap_sum  <= n_cap_sum;
            r_cur_mv   <= n_cur_mv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_good) begin
            r_cap_ring[r_cap_wr] <= w_sample;
        end
    end

    // First moving average and clamp.
    assign w_adv2 = r_s1_valid && w_rdy2;

    tstt_avg4 u_avg_two (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv2),
        .i_prime (!r_primed),
        .i_value (r_s1_mv),
        .o_avg   (w_avg2)
    );

    always_comb begin
        w_clamp2 = w_avg2;
        if (w_avg2 > tstt_pkg::CLAMP_HIGH) begin
            w_clamp2 = tstt_pkg::CLAMP_HIGH;
        end
        if (w_avg2 < tstt_pkg::CLAMP_LOW) begin
            w_clamp2 = tstt_pkg::CLAMP_LOW;
        end
    end

    // Second moving average, primed by the same transaction as the first.
    assign w_adv3 = r_s2_valid && w_rdy3;

    tstt_avg4 u_avg_three (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv3),
        .i_prime (r_s2_prime),
        .i_value (r_s2_mv),
        .o_avg   (w_avg3)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
            r_o_valid  <= 1'b0;
            r_primed   <= 1'b0;
            r_s2_prime <= 1'b0;
        end else begin
            if (w_rdy1) begin
                r_s1_valid <= w_good && r_enable;
            end
            if (w_rdy2) begin
                r_s2_valid <= r_s1_valid;
                r_s2_prime <= r_s1_valid && !r_primed;
            end
            if (w_adv2) begin
                r_primed <= 1'b1;
            end
            if (w_rdy3) begin
                r_s3_valid <= r_s2_valid;
            end
            if (w_rdy_out) begin
                r_o_valid <= r_s3_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy1) begin
            r_s1_mv <= n_cur_mv;
        end
        if (w_rdy2) begin
            r_s2_mv <= w_clamp2;
        end
        if (w_rdy3) begin
            r_s3_mv <= w_avg3;
        end
        if (w_rdy_out) begin
            r_o_temp <= tstt_pkg::lookup_temp(r_s3_mv);
            r_o_mv   <= r_s3_mv;
        end
    end

    assign o_m_tvalid = r_o_valid;
    assign o_m_tdata  = {5'd0, r_o_mv, r_o_temp};

    `ASSERT_ALWAYS(a_fill_sat, i_clk, i_rst_n, r_cap_fill <= tstt_pkg::CAP_FILL_W'(tstt_pkg::CAP_DEPTH + 1), "capture fill count passed saturation")
    `ASSERT_ALWAYS(a_out_range, i_clk, i_rst_n, !r_o_valid || (r_o_mv >= tstt_pkg::CLAMP_LOW && r_o_mv <= tstt_pkg::CLAMP_HIGH), "filtered value outside clamp range")
    `ASSERT_ALWAYS(a_primed_before_s3, i_clk, i_rst_n, !(r_s2_valid || r_s3_valid) || r_primed, "averaging stage loaded before priming")
    `ASSERT_NEXT(a_disabled_no_entry, i_clk, i_rst_n, w_rdy1 && !r_enable, !r_s1_valid, "transaction entered the averages while disabled")

endmodule

FILE: tb/temperature_reading_checker.sv
`timescale 1ns / 1ps

// Watches both streams and the enable register, forms the temperature
// readings the block ought to produce and compares each output transaction
// with the oldest one still owed.
module temperature_reading_checker
    import tstt_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wen,
    input  logic        i_cfg_wdata,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [15:0] i_s_tdata,    // [11:0] sample_mv, zero padding above
    input  logic        i_s_tuser,    // sample_bad
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [23:0] i_m_tdata,    // [6:0] temperature_c, [18:7] filtered_mv
    output int          o_errors,
    output int          o_pending
);

    typedef logic [MV_W-1:0] mv_t;

    typedef struct packed {
        logic signed [TEMP_W-1:0] temp_c;
        mv_t                      filt_mv;
    } reading_t;

    localparam mv_t LOW_MV       = 200;
    localparam mv_t HIGH_MV      = 2600;
    localparam int  BELOW_TEMP   = 60;
    localparam int  FIRST_TEMP   = -10;
    localparam int  N_STEPS      = 67;

    // One threshold per degree, coldest first.
    localparam mv_t DEGREE_STEPS [N_STEPS] = '{
        1482, 1467, 1452, 1437, 1422, 1407, 1392, 1377, 1362, 1347,
        1332, 1318, 1303, 1288, 1273, 1258, 1240, 1210, 1180, 1150,
        1130, 1110, 1090, 1070, 1050, 1030, 1010, 994, 977, 962,
        946, 931, 915, 900, 884, 869, 853, 838, 822, 807,
        791, 776, 760, 745, 729, 714, 698, 683, 667, 652,
        637, 621, 606, 590, 580, 565, 550, 535, 520, 505,
        490, 475, 460, 445, 430, 415, 400
    };

    logic       enabled;
    mv_t        cap_ring [CAP_DEPTH];
    int         cap_wr;
    int         cap_count;
    mv_t        held_mv;
    mv_t        first_avg [4];
    logic [1:0] first_ptr;
    logic       primed;
    mv_t        second_avg [4];
    logic [1:0] second_ptr;
    reading_t   pending_readings [$];
    int         errors = 0;

    function automatic mv_t mean_of_four(input mv_t r [4]);
        int total;
        total = int'(r[0]) + int'(r[1]) + int'(r[2]) + int'(r[3]);
        return mv_t'(total / 4);
    endfunction

    function automatic logic signed [TEMP_W-1:0] mv_to_celsius(input mv_t v);
        int   deg;
        logic hit;
        deg = BELOW_TEMP;
        hit = 1'b0;
        for (int i = 0; i < N_STEPS; i++) begin
            if (!hit && v >= DEGREE_STEPS[i]) begin
                hit = 1'b1;
                deg = FIRST_TEMP + i;
            end
        end
        return TEMP_W'(deg);
    endfunction

    task automatic take_sample(input mv_t s);
        int unsigned sum;
        mv_t         v;
        reading_t    want;
        cap_ring[cap_wr] = s;
        cap_wr = (cap_wr + 1 >= CAP_DEPTH) ? 0 : cap_wr + 1;
        if (cap_count < CAP_DEPTH + 1) begin
            cap_count++;
        end
        if (cap_count > CAP_DEPTH) begin
            sum = 0;
            foreach (cap_ring[i]) begin
                sum += cap_ring[i];
            end
            held_mv = mv_t'(sum / CAP_DEPTH);
        end else if (held_mv == '0) begin
            held_mv = s;
        end
        if (!enabled) begin
            return;
        end
        // The first enabled sample fills both averaging windows at once.
        if (!primed) begin
            foreach (first_avg[i]) begin
                first_avg[i] = held_mv;
            end
            first_ptr = 2'd1;
        end else begin
            first_avg[first_ptr] = held_mv;
            first_ptr++;
        end
        v = mean_of_four(first_avg);
        if (v > HIGH_MV) begin
            v = HIGH_MV;
        end
        if (v < LOW_MV) begin
            v = LOW_MV;
        end
        if (!primed) begin
            foreach (second_avg[i]) begin
                second_avg[i] = v;
            end
            second_ptr = 2'd2;
        end else begin
            second_avg[second_ptr] = v;
            second_ptr++;
        end
        primed = 1'b1;
        want.filt_mv = mean_of_four(second_avg);
        want.temp_c  = mv_to_celsius(want.filt_mv);
        pending_readings.push_back(want);
    endtask

    task automatic check_reading(input logic [23:0] data);
        logic signed [TEMP_W-1:0] got_temp;
        mv_t                      got_mv;
        reading_t                 want;
        got_temp = data[TEMP_W-1:0];
        got_mv   = data[TEMP_W+MV_W-1:TEMP_W];
        if (pending_readings.size() == 0) begin
            $display("%0t: unexpected reading: temperature %0d, filtered %0d mV",
                     $time, got_temp, got_mv);
            errors++;
            return;
        end
        want = pending_readings.pop_front();
        if (got_temp !== want.temp_c) begin
            $display("%0t: temperature mismatch: expected %0d, actual %0d",
                     $time, $signed(want.temp_c), got_temp);
            errors++;
        end
        if (got_mv !== want.filt_mv) begin
            $display("%0t: filtered mV mismatch: expected %0d, actual %0d",
                     $time, want.filt_mv, got_mv);
            errors++;
        end
    endtask

    always @(posedge i_clk) begin : track
        if (!i_rst_n) begin
            enabled    = 1'b0;
            cap_wr     = 0;
            cap_count  = 0;
            held_mv    = '0;
            first_ptr  = '0;
            second_ptr = '0;
            primed     = 1'b0;
            pending_readings.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                check_reading(i_m_tdata);
            end
            if (i_cfg_wen) begin
                enabled = i_cfg_wdata;
            end
            if (i_s_tvalid && i_s_tready && !i_s_tuser) begin
                take_sample(i_s_tdata[MV_W-1:0]);
            end
        end
        o_errors  <= errors;
        o_pending <= pending_readings.size();
    end

endmodule

FILE: tb/tb_thermistor_sample_to_temperature.sv
`timescale 1ns / 1ps

module tb_thermistor_sample_to_temperature;
    import tstt_pkg::*;

    localparam int CYCLE_LIMIT  = 500000;
    localparam int RANDOM_ITEMS = 2000;
    localparam int SETTLE       = 12;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        cfg_wen   = 1'b0;
    logic        cfg_wdata = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic [15:0] s_tdata   = '0;
    logic        s_tuser   = 1'b0;
    logic        m_tready  = 1'b0;
    logic        s_tready;
    logic        m_tvalid;
    logic [23:0] m_tdata;
    int          errors;
    int          pending;
    int          cycles    = 0;
    logic        rush      = 1'b0;

    always #4 clk = ~clk;

    thermistor_sample_to_temperature uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_wen   (cfg_wen),
        .i_cfg_wdata (cfg_wdata),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata)
    );

    temperature_reading_checker checker_i (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_wen   (cfg_wen),
        .i_cfg_wdata (cfg_wdata),
        .i_s_tvalid  (s_tvalid),
        .i_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .i_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .i_m_tdata   (m_tdata),
        .o_errors    (errors),
        .o_pending   (pending)
    );

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("FAIL thermistor_sample_to_temperature");
            $finish;
        end
    end

    // Reading sink: a fresh stall before every transaction, none while rushing.
    initial begin : reading_sink
        int stall;
        forever begin
            stall = rush ? 0 : $urandom_range(0, 14);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
        end
    end

    // Leaves tvalid high on return so that back-to-back transactions need no
    // second assignment in the same step.
    task automatic send_sample(input logic [MV_W-1:0] mv, input logic bad);
        int gap;
        gap = rush ? 0 : $urandom_range(0, 14);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(16 - MV_W){1'b0}}, mv};
        s_tuser  <= bad;
        do @(posedge clk); while (!s_tready);
    endtask

    // Stops the sender, waits for every owed reading and lets the pipeline empty.
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_enable(input logic value);
        cfg_wen   <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_wen   <= 1'b0;
    endtask

    function automatic logic [MV_W-1:0] pick_mv(input int level);
        int mv;
        case ($urandom_range(0, 9))
            6:       mv = $urandom_range(0, 4095);
            7:       mv = 0;
            8:       mv = 4095;
            9:       mv = $urandom_range(300, 1600);
            default: mv = level + int'($urandom_range(0, 200)) - 100;
        endcase
        if (mv < 0) begin
            mv = 0;
        end
        if (mv > 4095) begin
            mv = 4095;
        end
        return MV_W'(mv);
    endfunction

    initial begin : stimulus
        int   good_sent;
        int   phase_len;
        int   level;
        logic bad;
        good_sent = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // A zero first sample primes both windows with zero, clamped to the floor.
        write_enable(1'b1);
        send_sample(12'd0, 1'b0);
        send_sample(12'd4095, 1'b1);
        send_sample(12'd0, 1'b0);
        send_sample(12'd4095, 1'b0);
        send_sample(12'd1, 1'b0);
        send_sample(12'd2048, 1'b0);
        send_sample(12'd4095, 1'b0);
        send_sample(12'd0, 1'b0);
        send_sample(12'd4095, 1'b0);
        // The capture ring is now full, so from the next sample on the mean takes over.
        send_sample(12'd2600, 1'b0);
        send_sample(12'd1482, 1'b0);
        send_sample(12'd400, 1'b0);
        send_sample(12'd399, 1'b0);
        send_sample(12'd1483, 1'b0);
        settle();
        write_enable(1'b0);
        send_sample(12'd4095, 1'b0);
        send_sample(12'd0, 1'b1);
        send_sample(12'd1000, 1'b0);
        settle();
        // Re-enabling must not prime the windows a second time.
        write_enable(1'b1);
        send_sample(12'd1000, 1'b0);
        send_sample(12'd1000, 1'b0);

        while (good_sent < RANDOM_ITEMS) begin
            settle();
            write_enable($urandom_range(0, 4) != 0);
            rush      = ($urandom_range(0, 3) == 0);
            level     = $urandom_range(150, 2800);
            phase_len = $urandom_range(40, 250);
            for (int k = 0; k < phase_len; k++) begin
                bad = ($urandom_range(0, 9) == 0);
                send_sample(pick_mv(level), bad);
                if (!bad) begin
                    good_sent++;
                end
            end
        end

        rush = 1'b0;
        settle();
        if (errors == 0 && pending == 0) begin
            $display("PASS thermistor_sample_to_temperature");
        end else begin
            $display("FAIL thermistor_sample_to_temperature");
        end
        $finish;
    end

endmodule
